[rtl/tlex_pkg.sv]
// ---------------------------------------------------------------------------
// tlex_pkg
// Shared types and constants of the token lexer: character codes, result
// kinds and the result word layout.
// ---------------------------------------------------------------------------
package tlex_pkg;

    localparam int ByteW  = 8;
    localparam int KindW  = 2;
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [ByteW-1:0] ChNul   = 8'h00;
    localparam logic [ByteW-1:0] ChTab   = 8'h09;
    localparam logic [ByteW-1:0] ChLf    = 8'h0A;
    localparam logic [ByteW-1:0] ChCr    = 8'h0D;
    localparam logic [ByteW-1:0] ChSpace = 8'h20;
    localparam logic [ByteW-1:0] ChQuote = 8'h22;
    localparam logic [ByteW-1:0] ChSlash = 8'h2F;
    localparam logic [ByteW-1:0] ChBslash = 8'h5C;

    typedef enum logic [KindW-1:0] {
        K_BYTE   = 2'd0,
        K_END    = 2'd1,
        K_EOT    = 2'd2,
        K_UNTERM = 2'd3
    } t_kind;

    typedef struct packed {
        logic [ByteW-1:0] data;
        t_kind            kind;
        logic             str;
        logic             last;
    } t_res;

endpackage

[rtl/token_lexer_with_strings_unit.sv]
// ---------------------------------------------------------------------------
// token_lexer_with_strings_unit
// Byte-serial lexer that splits a text into plain tokens and quoted strings.
// ---------------------------------------------------------------------------
// The block takes one text byte per word on the slave side and can accept a
// byte in every clock cycle in which the four-entry result queue has room
// for two words, so the input keeps moving while earlier results wait. Each
// byte yields zero, one or two result words, which are produced in the cycle
// of acceptance and registered into the queue behind any waiting words. The
// master side delivers one word per cycle while the receiver is ready, so
// the sustained rate is one byte per cycle as long as bytes average no more
// than one result word; bytes that end a token and start another (or end
// the text) produce two words and then the output port sets the pace.
// Byte 0 ends the text and returns the lexer to idle.
// ---------------------------------------------------------------------------
module token_lexer_with_strings_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [1:0] result_kind, [2] is_string
    output logic       m_axis_tlast    // last
);

    typedef enum logic [2:0] {
        M_IDLE   = 3'd0,
        M_TOKEN  = 3'd1,
        M_STR    = 3'd2,
        M_ESC    = 3'd3,
        M_CFIRST = 3'd4,
        M_CBODY  = 3'd5
    } t_mode;

    typedef struct packed {
        logic         has;
        tlex_pkg::t_res res;
        t_mode        mode;
    } t_bt;

    function automatic tlex_pkg::t_res mk_res(logic [7:0] b, tlex_pkg::t_kind k,
                                              logic s);
        tlex_pkg::t_res r;
        r.data = b;
        r.kind = k;
        r.str  = s;
        r.last = 1'b0;
        return r;
    endfunction

    // Handling of a byte that arrives between tokens.
    function automatic t_bt between_tokens(logic [7:0] c);
        t_bt o;
        o.has  = 1'b0;
        o.res  = mk_res(8'h00, tlex_pkg::K_BYTE, 1'b0);
        o.mode = M_IDLE;
        if (c == tlex_pkg::ChNul) begin
            o.has = 1'b1;
            o.res = mk_res(8'h00, tlex_pkg::K_EOT, 1'b0);
        end else if (c == tlex_pkg::ChSpace || c == tlex_pkg::ChTab ||
                     c == tlex_pkg::ChCr || c == tlex_pkg::ChLf) begin
            o.mode = M_IDLE;
        end else if (c == tlex_pkg::ChSlash) begin
            o.mode = M_CFIRST;
        end else if (c == tlex_pkg::ChQuote) begin
            o.mode = M_STR;
        end else begin
            o.has  = 1'b1;
            o.res  = mk_res(c, tlex_pkg::K_BYTE, 1'b0);
            o.mode = M_TOKEN;
        end
        return o;
    endfunction

    t_mode r_mode, n_mode;

    tlex_pkg::t_res r_q [tlex_pkg::QDepth];
    logic [tlex_pkg::QPtrW-1:0] r_wr, r_rd;
    logic [tlex_pkg::QCntW-1:0] r_cnt, n_cnt;

    logic [7:0]     c;
    logic [1:0]     nres;
    tlex_pkg::t_res res0, res1;
    t_bt            bt;
    logic           in_acc, out_acc;

    assign c             = s_axis_tdata;
    assign s_axis_tready = (r_cnt <= tlex_pkg::QCntW'(tlex_pkg::QDepth - 2));
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_cnt != '0);
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    always_comb begin
        nres   = 2'd0;
        res0   = mk_res(8'h00, tlex_pkg::K_BYTE, 1'b0);
        res1   = res0;
        n_mode = r_mode;
        bt     = between_tokens(c);
        case (r_mode)
            M_TOKEN: begin
                if (c > tlex_pkg::ChSpace && c != tlex_pkg::ChQuote) begin
                    nres = 2'd1;
                    res0 = mk_res(c, tlex_pkg::K_BYTE, 1'b0);
                end else begin
                    res0   = mk_res(8'h00, tlex_pkg::K_END, 1'b0);
                    res1   = bt.res;
                    nres   = bt.has ? 2'd2 : 2'd1;
                    n_mode = bt.mode;
                end
            end
            M_STR: begin
                if (c == tlex_pkg::ChQuote) begin
                    nres   = 2'd1;
                    res0   = mk_res(8'h00, tlex_pkg::K_END, 1'b1);
                    n_mode = M_IDLE;
                end else if (c == tlex_pkg::ChBslash) begin
                    n_mode = M_ESC;
                end else if (c == tlex_pkg::ChNul) begin
                    nres   = 2'd1;
                    res0   = mk_res(8'h00, tlex_pkg::K_UNTERM, 1'b1);
                    n_mode = M_IDLE;
                end else if (c != tlex_pkg::ChCr) begin
                    nres = 2'd1;
                    res0 = mk_res(c, tlex_pkg::K_BYTE, 1'b1);
                end
            end
            M_ESC: begin
                if (c == tlex_pkg::ChNul) begin
                    nres   = 2'd1;
                    res0   = mk_res(8'h00, tlex_pkg::K_UNTERM, 1'b1);
                    n_mode = M_IDLE;
                end else begin
                    // An escaped CR is still dropped.
                    if (c != tlex_pkg::ChCr) begin
                        nres = 2'd1;
                        res0 = mk_res(c, tlex_pkg::K_BYTE, 1'b1);
                    end
                    n_mode = M_STR;
                end
            end
            M_CFIRST: begin
                if (c == tlex_pkg::ChNul) begin
                    nres   = 2'd1;
                    res0   = mk_res(8'h00, tlex_pkg::K_EOT, 1'b0);
                    n_mode = M_IDLE;
                end else begin
                    n_mode = M_CBODY;
                end
            end
            M_CBODY: begin
                if (c == tlex_pkg::ChNul) begin
                    nres   = 2'd1;
                    res0   = mk_res(8'h00, tlex_pkg::K_EOT, 1'b0);
                    n_mode = M_IDLE;
                end else if (c == tlex_pkg::ChLf) begin
                    n_mode = M_IDLE;
                end
            end
            default: begin
                nres   = bt.has ? 2'd1 : 2'd0;
                res0   = bt.res;
                n_mode = bt.mode;
            end
        endcase
        if (nres == 2'd2) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (in_acc) begin
            n_cnt = n_cnt + tlex_pkg::QCntW'(nres);
        end
        if (out_acc) begin
            n_cnt = n_cnt - tlex_pkg::QCntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (in_acc) begin
                r_mode <= n_mode;
                r_wr   <= r_wr + tlex_pkg::QPtrW'(nres);
            end
            if (out_acc) begin
                r_rd <= r_rd + tlex_pkg::QPtrW'(1);
            end
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (in_acc && nres != 2'd0) begin
            r_q[r_wr] <= res0;
        end
        if (in_acc && nres == 2'd2) begin
            r_q[r_wr + tlex_pkg::QPtrW'(1)] <= res1;
        end
    end

    assign m_axis_tdata = r_q[r_rd].data;
    assign m_axis_tuser = {r_q[r_rd].str, r_q[r_rd].kind};
    assign m_axis_tlast = r_q[r_rd].last;

endmodule

[sim/tb_token_lexer_with_strings_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_token_lexer_with_strings_unit
// Self-checking bench for the byte-serial token lexer. Text bytes go in on
// the slave stream. A small scoreboard tracks the lexer mode and queues the
// result words that each byte should produce. Every word on the master
// stream is compared field by field against the oldest queued word. Both
// streams idle at random, and one long receiver hold-off fills the block.
// ---------------------------------------------------------------------------
module tb_token_lexer_with_strings_unit;

    localparam int RandomItems = 850;
    localparam int HoldCycles  = 300;
    localparam int DrainCycles = 20;
    localparam int CycleLimit  = 500000;
    localparam int DirCount    = 27;

    // Covers token bytes at both ends of the range, quotes, escapes, CR,
    // empty strings, comments and a text-ending zero byte in four lexer modes.
    localparam logic [7:0] DirText [DirCount] = '{
        8'h01, 8'hFF, 8'h80, tlex_pkg::ChQuote, tlex_pkg::ChBslash,
        tlex_pkg::ChCr, tlex_pkg::ChCr, tlex_pkg::ChBslash, tlex_pkg::ChQuote,
        tlex_pkg::ChQuote, tlex_pkg::ChQuote, tlex_pkg::ChQuote, 8'h7F,
        tlex_pkg::ChSpace, tlex_pkg::ChSlash, tlex_pkg::ChNul, tlex_pkg::ChSlash,
        tlex_pkg::ChLf, 8'h41, tlex_pkg::ChLf, tlex_pkg::ChQuote,
        tlex_pkg::ChBslash, tlex_pkg::ChNul, tlex_pkg::ChQuote, tlex_pkg::ChNul,
        8'h41, tlex_pkg::ChNul
    };

    typedef enum logic [2:0] {
        LM_IDLE    = 3'd0,
        LM_TOKEN   = 3'd1,
        LM_STRING  = 3'd2,
        LM_ESCAPE  = 3'd3,
        LM_SLASH   = 3'd4,
        LM_COMMENT = 3'd5
    } t_lex_mode;

    class t_lex_scoreboard;
        t_lex_mode      mode;
        tlex_pkg::t_res pending[$];
        int             errors;
        int             words;
        int             pair_bytes;
        int             eot_words;
        int             unterm_words;
        int             string_ends;

        function new();
            mode = LM_IDLE;
            errors = 0;
            words = 0;
            pair_bytes = 0;
            eot_words = 0;
            unterm_words = 0;
            string_ends = 0;
        endfunction

        function void add_word(logic [7:0] d, tlex_pkg::t_kind k, logic s);
            tlex_pkg::t_res r;
            r.data = d;
            r.kind = k;
            r.str  = s;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        // Handles a byte the way it is handled between tokens.
        function void lex_idle(logic [7:0] c);
            case (c)
                tlex_pkg::ChNul: begin
                    add_word(8'h00, tlex_pkg::K_EOT, 1'b0);
                    mode = LM_IDLE;
                end
                tlex_pkg::ChSpace, tlex_pkg::ChTab, tlex_pkg::ChCr,
                tlex_pkg::ChLf: mode = LM_IDLE;
                tlex_pkg::ChSlash: mode = LM_SLASH;
                tlex_pkg::ChQuote: mode = LM_STRING;
                default: begin
                    add_word(c, tlex_pkg::K_BYTE, 1'b0);
                    mode = LM_TOKEN;
                end
            endcase
        endfunction

        function void note_byte(logic [7:0] c);
            int             n0;
            tlex_pkg::t_res tail;
            n0 = pending.size();
            case (mode)
                LM_TOKEN: begin
                    if (c > tlex_pkg::ChSpace && c != tlex_pkg::ChQuote) begin
                        add_word(c, tlex_pkg::K_BYTE, 1'b0);
                    end else begin
                        add_word(8'h00, tlex_pkg::K_END, 1'b0);
                        lex_idle(c);
                    end
                end
                LM_STRING: begin
                    if (c == tlex_pkg::ChQuote) begin
                        add_word(8'h00, tlex_pkg::K_END, 1'b1);
                        mode = LM_IDLE;
                    end else if (c == tlex_pkg::ChBslash) begin
                        mode = LM_ESCAPE;
                    end else if (c == tlex_pkg::ChNul) begin
                        add_word(8'h00, tlex_pkg::K_UNTERM, 1'b1);
                        mode = LM_IDLE;
                    end else if (c != tlex_pkg::ChCr) begin
                        add_word(c, tlex_pkg::K_BYTE, 1'b1);
                    end
                end
                LM_ESCAPE: begin
                    if (c == tlex_pkg::ChNul) begin
                        add_word(8'h00, tlex_pkg::K_UNTERM, 1'b1);
                        mode = LM_IDLE;
                    end else begin
                        // An escaped CR is still dropped.
                        if (c != tlex_pkg::ChCr)
                            add_word(c, tlex_pkg::K_BYTE, 1'b1);
                        mode = LM_STRING;
                    end
                end
                LM_SLASH: begin
                    if (c == tlex_pkg::ChNul) begin
                        add_word(8'h00, tlex_pkg::K_EOT, 1'b0);
                        mode = LM_IDLE;
                    end else begin
                        mode = LM_COMMENT;
                    end
                end
                LM_COMMENT: begin
                    if (c == tlex_pkg::ChNul) begin
                        add_word(8'h00, tlex_pkg::K_EOT, 1'b0);
                        mode = LM_IDLE;
                    end else if (c == tlex_pkg::ChLf) begin
                        mode = LM_IDLE;
                    end
                end
                default: lex_idle(c);
            endcase
            if (pending.size() > n0) begin
                tail = pending.pop_back();
                tail.last = 1'b1;
                pending.push_back(tail);
            end
            if (pending.size() - n0 == 2)
                pair_bytes++;
        endfunction

        function void check_word(tlex_pkg::t_res got);
            tlex_pkg::t_res want;
            words++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: data=%h kind=%0d str=%b last=%b",
                         $time, got.data, got.kind, got.str, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.data !== want.data) begin
                errors++;
                $display("%0t: out_byte mismatch: expected %h, actual %h",
                         $time, want.data, got.data);
            end
            if (got.kind !== want.kind) begin
                errors++;
                $display("%0t: result_kind mismatch: expected %0d, actual %0d",
                         $time, want.kind, got.kind);
            end
            if (got.str !== want.str) begin
                errors++;
                $display("%0t: is_string mismatch: expected %b, actual %b",
                         $time, want.str, got.str);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last mismatch: expected %b, actual %b",
                         $time, want.last, got.last);
            end
            if (want.kind == tlex_pkg::K_EOT)
                eot_words++;
            if (want.kind == tlex_pkg::K_UNTERM)
                unterm_words++;
            if (want.kind == tlex_pkg::K_END && want.str)
                string_ends++;
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] out_byte
    logic [2:0] m_axis_tuser;    // [1:0] result_kind, [2] is_string
    logic       m_axis_tlast;

    t_lex_scoreboard sb = new();
    int idle_pct  = 0;
    int n_sent    = 0;
    int cycle_cnt = 0;
    bit hold_req  = 1'b0;

    token_lexer_with_strings_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(33, 255)); while (b == tlex_pkg::ChQuote);
        return b;
    endfunction

    // Offers one word and returns at the edge where it was taken, or after
    // the idle gap that follows it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
        n_sent++;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = pick_gap();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sends one well-formed piece of text most of the time, raw noise else.
    task automatic send_text_piece();
        int         len;
        int         sel;
        logic [7:0] b;
        sel = $urandom_range(0, 99);
        if (sel < 22) begin
            len = $urandom_range(1, 3);
            repeat (len) begin
                case ($urandom_range(0, 3))
                    0: send_byte(tlex_pkg::ChSpace);
                    1: send_byte(tlex_pkg::ChTab);
                    2: send_byte(tlex_pkg::ChCr);
                    default: send_byte(tlex_pkg::ChLf);
                endcase
            end
        end else if (sel < 52) begin
            if ($urandom_range(0, 9) == 0) begin
                do b = 8'($urandom_range(1, 31));
                while (b == tlex_pkg::ChTab || b == tlex_pkg::ChLf || b == tlex_pkg::ChCr);
            end else begin
                do b = token_byte(); while (b == tlex_pkg::ChSlash);
            end
            send_byte(b);
            len = $urandom_range(0, 7);
            repeat (len) send_byte(token_byte());
        end else if (sel < 74) begin
            send_byte(tlex_pkg::ChQuote);
            len = $urandom_range(0, 8);
            repeat (len) begin
                sel = $urandom_range(0, 99);
                if (sel < 10) begin
                    send_byte(tlex_pkg::ChBslash);
                    send_byte(8'($urandom_range(1, 255)));
                end else if (sel < 15) begin
                    send_byte(tlex_pkg::ChCr);
                end else begin
                    do b = 8'($urandom_range(1, 255));
                    while (b == tlex_pkg::ChQuote || b == tlex_pkg::ChBslash);
                    send_byte(b);
                end
            end
            // Now and then the string is left open and runs into what follows.
            if ($urandom_range(0, 9) != 0)
                send_byte(tlex_pkg::ChQuote);
        end else if (sel < 85) begin
            send_byte(tlex_pkg::ChSlash);
            send_byte(8'($urandom_range(1, 255)));
            len = $urandom_range(0, 6);
            repeat (len) begin
                do b = 8'($urandom_range(1, 255)); while (b == tlex_pkg::ChLf);
                send_byte(b);
            end
            send_byte(tlex_pkg::ChLf);
        end else if (sel < 90) begin
            send_byte(tlex_pkg::ChNul);
        end else begin
            len = $urandom_range(1, 4);
            repeat (len) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(tlex_pkg::t_res'{data: m_axis_tdata,
                                           kind: tlex_pkg::t_kind'(m_axis_tuser[1:0]),
                                           str: m_axis_tuser[2], last: m_axis_tlast});
    end

    // Receiver back-pressure, including the one long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n)
                continue;
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HoldCycles;
            end else if (stall == 0 && $urandom_range(0, 99) < idle_pct) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CycleLimit) begin
            $display("%0t: timeout after %0d cycles, %0d words still expected",
                     $time, cycle_cnt, sb.pending.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int  next_phase;
        bit  held;
        bit  paused;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        m_axis_tready = 1'b0;
        next_phase    = DirCount;
        held          = 1'b0;
        paused        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DirText[i])
            send_byte(DirText[i]);

        while (n_sent < DirCount + RandomItems) begin
            if (n_sent >= next_phase) begin
                case ($urandom_range(0, 3))
                    0: idle_pct = 0;
                    1: idle_pct = 5;
                    2: idle_pct = 25;
                    default: idle_pct = 50;
                endcase
                next_phase += 120;
            end
            if (!held && n_sent >= 300) begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && n_sent >= 600) begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (sb.pending.size() != 0);
            end
            send_text_piece();
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Lexed %0d text bytes into %0d result words; %0d bytes gave two words.",
                 n_sent, sb.words, sb.pair_bytes);
        $display("Seen %0d closed strings, %0d text ends, %0d unterminated strings.",
                 sb.string_ends, sb.eot_words, sb.unterm_words);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
